// File: design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by cartridge_bank_mapper_top.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, masked during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: design/cbm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbm_pkg
// Shared types and constants for the cartridge bank mapper.
// ---------------------------------------------------------------------------
package cbm_pkg;

    localparam int ROM_BANK_W_MAX   = 9;
    localparam int RAM_BANK_W_MAX   = 8;
    localparam int ROM_BANK_BITS_DEF = 9;
    localparam int RAM_BANK_BITS_DEF = 8;

    localparam int ADDR_W      = 16;
    localparam int PHYS_W      = 23;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_DATA_W  = 3;

    // target memory codes
    localparam logic [1:0] MEM_INTERNAL = 2'd0;
    localparam logic [1:0] MEM_ROM      = 2'd1;
    localparam logic [1:0] MEM_RAM      = 2'd2;

    // config register indexes
    localparam logic CFG_BANKING_EN = 1'b0;
    localparam logic CFG_CTRL_MODEL = 1'b1;

    // controller models
    localparam logic [2:0] MODEL_MBC1 = 3'd1;
    localparam logic [2:0] MODEL_MBC5 = 3'd5;

    // bus commands
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // bus address map
    localparam logic [15:0] A_ROM_LO_END  = 16'h2000;
    localparam logic [15:0] A_MBC5_LO_END = 16'h3000;
    localparam logic [15:0] A_ROM_BANKED  = 16'h4000;
    localparam logic [15:0] A_MODE_REG    = 16'h6000;
    localparam logic [15:0] A_VRAM        = 16'h8000;
    localparam logic [15:0] A_CART_RAM    = 16'hA000;
    localparam logic [15:0] A_WRAM        = 16'hC000;
    localparam logic [15:0] A_WRAM_MIR    = 16'hDE00;
    localparam logic [15:0] A_ECHO        = 16'hE000;
    localparam logic [15:0] A_ECHO_END    = 16'hFE00;
    localparam logic [15:0] ECHO_OFFSET   = 16'h2000;

    localparam logic [7:0] RAM_ENABLE_KEY = 8'h0A;
    localparam logic [7:0] MBC1_HOLE_20   = 8'h20;
    localparam logic [7:0] MBC1_HOLE_40   = 8'h40;
    localparam logic [7:0] MBC1_HOLE_60   = 8'h60;

    typedef struct packed {
        logic [1:0]        target_memory;
        logic [PHYS_W-1:0] physical_address;
        logic              write_enable;
        logic [7:0]        data_out;
        logic              last_access;
    } result_t;

    // current bank state, zero-extended to the widest supported size
    typedef struct packed {
        logic                      banking_en;
        logic [2:0]                ctrl_model;
        logic [ROM_BANK_W_MAX-1:0] rom_sel;
        logic [RAM_BANK_W_MAX-1:0] ram_sel;
        logic                      ram_en;
    } bank_state_t;

    // register updates produced by one bus word
    typedef struct packed {
        logic                      rom_we;
        logic [ROM_BANK_W_MAX-1:0] rom_val;
        logic                      ram_we;
        logic [RAM_BANK_W_MAX-1:0] ram_val;
        logic                      en_we;
        logic                      en_val;
    } bank_upd_t;

endpackage

// File: design/cartridge_bank_mapper_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cartridge_bank_mapper_top
// Bus words in on s_, one word per cycle unless stalled; memory commands out
// on m_. A word is taken into an input register, decoded against the current
// bank state and moved into the output register. Writes to the work RAM window
// or its echo window give two output words (mirror write first, then main
// write, tlast on the second), so they hold the input register until the main
// write is loaded. Bank register writes below 0x8000 on a banked cart give no
// output word and retire at once; the new bank applies to the very next word.
// Config writes take effect the next cycle; the user must make them only while
// the mapper is idle, which the block does not enforce. Throughput: one output
// word per cycle while m_tready is high, set by the single output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cartridge_bank_mapper_top #(
    parameter int ROM_BANK_BITS = cbm_pkg::ROM_BANK_BITS_DEF,
    parameter int RAM_BANK_BITS = cbm_pkg::RAM_BANK_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // config write port
    input  logic                               cfg_wr_en,
    input  logic                               cfg_index,  // 0 banking_enabled, 1 controller_model
    input  logic [cbm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // bus words in
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [0] command, [16:1] bus_address, [24:17] write_data, [31:25] zero
    input  logic [cbm_pkg::IN_TDATA_W-1:0]     s_tdata,
    // memory commands out
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [1:0] target_memory, [24:2] physical_address, [25] write_enable,
    // [33:26] data_out, [39:34] zero
    output logic [cbm_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                               m_tlast     // last_access
);
    import cbm_pkg::*;

    // input register
    logic              in_valid_reg;
    logic              cmd_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [7:0]        wdata_reg;
    logic              phase_reg;   // mirror word already sent

    // output register
    logic              out_valid_reg;
    result_t           out_reg;

    bank_state_t state;
    bank_upd_t   upd;
    logic        mirror_valid;
    logic        main_valid;
    result_t     mirror_res;
    result_t     main_res;

    logic        emit_mirror;
    logic        cur_valid;
    result_t     cur_res;
    logic        out_free;
    logic        out_load;
    logic        retire;

    cbm_bank_state #(
        .ROM_BANK_BITS (ROM_BANK_BITS),
        .RAM_BANK_BITS (RAM_BANK_BITS)
    ) u_state (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .upd_en    (retire),
        .upd       (upd),
        .state     (state)
    );

    cbm_decode u_decode (
        .command      (cmd_reg),
        .bus_address  (addr_reg),
        .write_data   (wdata_reg),
        .state        (state),
        .mirror_valid (mirror_valid),
        .mirror_res   (mirror_res),
        .main_valid   (main_valid),
        .main_res     (main_res),
        .upd          (upd)
    );

    // pick the word to send this cycle
    assign emit_mirror = mirror_valid && !phase_reg;
    assign cur_valid   = emit_mirror || main_valid;
    assign cur_res     = emit_mirror ? mirror_res : main_res;
    assign out_free    = !out_valid_reg || m_tready;
    assign out_load    = in_valid_reg && cur_valid && out_free;
    // the held word leaves once its last output is loaded, or at once if it has none
    assign retire      = in_valid_reg && (!cur_valid || (out_free && !emit_mirror));
    assign s_tready    = !in_valid_reg || retire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) in_valid_reg <= s_tvalid;

            if (retire)                       phase_reg <= 1'b0;
            else if (out_load && emit_mirror) phase_reg <= 1'b1;

            if (out_load)      out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            cmd_reg   <= s_tdata[0];
            addr_reg  <= s_tdata[16:1];
            wdata_reg <= s_tdata[24:17];
        end
        if (out_load) out_reg <= cur_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.last_access;
    assign m_tdata  = {6'd0, out_reg.data_out, out_reg.write_enable,
                       out_reg.physical_address, out_reg.target_memory};

    // mirror phase only exists while a word is held
    `ASSERT_IMPLY(a_phase_held, aclk, aresetn, phase_reg, in_valid_reg && mirror_valid)
    // sending the mirror word marks the phase for the main word
    `ASSERT_NEXT(a_phase_set, aclk, aresetn, out_load && emit_mirror, phase_reg)
    // a mirror word is never the last and a main word always is
    `ASSERT_IMPLY(a_last_order, aclk, aresetn, out_load, cur_res.last_access == !emit_mirror)

endmodule

// File: design/cbm_bank_state.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbm_bank_state
// Config registers plus ROM bank, RAM bank and RAM-enable registers.
// ---------------------------------------------------------------------------
module cbm_bank_state #(
    parameter int ROM_BANK_BITS = cbm_pkg::ROM_BANK_BITS_DEF,
    parameter int RAM_BANK_BITS = cbm_pkg::RAM_BANK_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic                              cfg_index,
    input  logic [cbm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              upd_en,
    input  cbm_pkg::bank_upd_t                upd,
    output cbm_pkg::bank_state_t              state
);
    import cbm_pkg::*;

    logic                     banking_en_reg;
    logic [2:0]               ctrl_model_reg;
    logic [ROM_BANK_BITS-1:0] rom_sel_reg;
    logic [RAM_BANK_BITS-1:0] ram_sel_reg;
    logic                     ram_en_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            banking_en_reg <= 1'b1;
            ctrl_model_reg <= MODEL_MBC1;
            rom_sel_reg    <= ROM_BANK_BITS'(1);
            ram_sel_reg    <= '0;
            ram_en_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_BANKING_EN: banking_en_reg <= cfg_wdata[0];
                    CFG_CTRL_MODEL: ctrl_model_reg <= cfg_wdata;
                    default:        ;
                endcase
            end
            if (upd_en && upd.rom_we) rom_sel_reg <= upd.rom_val[ROM_BANK_BITS-1:0];
            if (upd_en && upd.ram_we) ram_sel_reg <= upd.ram_val[RAM_BANK_BITS-1:0];
            if (upd_en && upd.en_we)  ram_en_reg  <= upd.en_val;
        end
    end

    assign state.banking_en = banking_en_reg;
    assign state.ctrl_model = ctrl_model_reg;
    assign state.rom_sel    = ROM_BANK_W_MAX'(rom_sel_reg);
    assign state.ram_sel    = RAM_BANK_W_MAX'(ram_sel_reg);
    assign state.ram_en     = ram_en_reg;

endmodule

// File: design/cbm_decode.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbm_decode
// Address decode: maps one bus word to up to two memory commands and
// the bank register updates it causes.
// ---------------------------------------------------------------------------
module cbm_decode (
    input  logic                          command,
    input  logic [cbm_pkg::ADDR_W-1:0]    bus_address,
    input  logic [7:0]                    write_data,
    input  cbm_pkg::bank_state_t          state,
    output logic                          mirror_valid,
    output cbm_pkg::result_t              mirror_res,
    output logic                          main_valid,
    output cbm_pkg::result_t              main_res,
    output cbm_pkg::bank_upd_t            upd
);
    import cbm_pkg::*;

    logic [ADDR_W-1:0] a;
    logic [PHYS_W-1:0] rom_phys;
    logic [PHYS_W-1:0] ram_phys;
    logic [PHYS_W-1:0] int_phys;
    logic [7:0]        bank_v;
    logic [ROM_BANK_W_MAX-1:0] bank_remap;
    logic              is_mbc5;

    assign a        = bus_address;
    assign rom_phys = {state.rom_sel, a[13:0]};
    assign ram_phys = {2'b00, state.ram_sel, a[12:0]};
    assign int_phys = PHYS_W'(a);
    assign is_mbc5  = (state.ctrl_model == MODEL_MBC5);
    assign bank_v   = (write_data == 8'd0) ? 8'd1 : write_data;

    // MBC1 skips banks 0x20/0x40/0x60
    always_comb begin
        bank_remap = ROM_BANK_W_MAX'(bank_v);
        if (state.ctrl_model == MODEL_MBC1 &&
            (write_data == MBC1_HOLE_20 || write_data == MBC1_HOLE_40 ||
             write_data == MBC1_HOLE_60))
            bank_remap = ROM_BANK_W_MAX'(write_data) + ROM_BANK_W_MAX'(1);
    end

    // echo mirror write, issued ahead of the main write
    always_comb begin
        mirror_valid                = 1'b0;
        mirror_res.target_memory    = MEM_INTERNAL;
        mirror_res.physical_address = int_phys;
        mirror_res.write_enable     = 1'b1;
        mirror_res.data_out         = write_data;
        mirror_res.last_access      = 1'b0;
        if (command == CMD_WRITE) begin
            if (a >= A_WRAM && a < A_WRAM_MIR) begin
                mirror_valid                = 1'b1;
                mirror_res.physical_address = PHYS_W'(a + ECHO_OFFSET);
            end else if (a >= A_ECHO && a < A_ECHO_END) begin
                mirror_valid                = 1'b1;
                mirror_res.physical_address = PHYS_W'(a - ECHO_OFFSET);
            end
        end
    end

    always_comb begin
        main_valid                = 1'b1;
        main_res.target_memory    = MEM_INTERNAL;
        main_res.physical_address = int_phys;
        main_res.write_enable     = command;
        main_res.data_out         = (command == CMD_WRITE) ? write_data : 8'd0;
        main_res.last_access      = 1'b1;
        upd                       = '0;

        if (command == CMD_READ) begin
            priority if (!state.banking_en || a < A_ROM_BANKED || a >= A_WRAM) begin
                main_res.target_memory = MEM_INTERNAL;
            end else if (a < A_VRAM) begin
                main_res.target_memory    = MEM_ROM;
                main_res.physical_address = rom_phys;
            end else if (a < A_CART_RAM || !state.ram_en) begin
                main_res.target_memory = MEM_INTERNAL;
            end else begin
                main_res.target_memory    = MEM_RAM;
                main_res.physical_address = ram_phys;
            end
        end else begin
            priority if (!state.banking_en || a >= A_WRAM) begin
                main_res.target_memory = MEM_INTERNAL;
            end else if (a < A_ROM_LO_END) begin
                main_valid = 1'b0;
                upd.en_we  = 1'b1;
                upd.en_val = (write_data == RAM_ENABLE_KEY);
            end else if (a < A_MBC5_LO_END && is_mbc5) begin
                main_valid  = 1'b0;
                upd.rom_we  = 1'b1;
                upd.rom_val = {state.rom_sel[ROM_BANK_W_MAX-1], bank_v};
            end else if (a < A_ROM_BANKED) begin
                main_valid  = 1'b0;
                upd.rom_we  = 1'b1;
                upd.rom_val = is_mbc5 ? {write_data[0], state.rom_sel[7:0]} : bank_remap;
            end else if (a < A_MODE_REG) begin
                main_valid  = 1'b0;
                upd.ram_we  = 1'b1;
                upd.ram_val = write_data;
            end else if (a < A_VRAM) begin
                main_valid = 1'b0;  // mode register not modeled
            end else if (a < A_CART_RAM) begin
                main_res.target_memory = MEM_INTERNAL;
            end else begin
                main_res.target_memory    = MEM_RAM;
                main_res.physical_address = ram_phys;
            end
        end
    end

endmodule
